[design/tsf_pkg.sv]
package tsf_pkg;

  localparam int QDEPTH_DEF = 4;

  localparam logic [31:0] DELIM_RESET = 32'h666C_6167;
  localparam logic [23:0] ESC_RESET   = 24'h65_7363;

  // register index, taken from paddr[2]
  localparam logic REG_DELIM = 1'b0;
  localparam logic REG_ESC   = 1'b1;

  // output phases of one job, in emission order
  typedef enum logic [5:0] {
    PH_OPEN  = 6'b000001,
    PH_PESC  = 6'b000010,
    PH_POP   = 6'b000100,
    PH_FESC  = 6'b001000,
    PH_FLUSH = 6'b010000,
    PH_CLOSE = 6'b100000
  } phase_t;

  // work for one accepted item
  typedef struct packed {
    logic            open;
    logic            pop_en;
    logic            pop_esc;
    logic [7:0]      pop_byte;
    logic [1:0]      flush_n;
    logic [2:0][7:0] flush_bytes;
    logic            flush_esc;
    logic            close;
  } job_t;

endpackage

[design/tsf_front.sv]
module tsf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic [7:0]         payload_byte,
  input  logic               frame_last,
  input  logic [31:0]        delim,
  input  logic [23:0]        esc,
  output logic               push,
  output tsf_pkg::job_t      job
);

  logic [1:0]      count_r, count_nxt;
  logic            inside_r, inside_nxt;
  logic [2:0][7:0] win_r, win_nxt;

  logic [1:0]      c0, c1, c2;
  logic            pop;
  logic [2:0][7:0] shifted;
  logic [23:0]     w3;

  always_comb begin
    c0      = inside_r ? count_r : 2'd0;
    pop     = (c0 == 2'd3);
    w3      = {win_r[0], win_r[1], win_r[2]};
    shifted = pop ? {win_r[2], win_r[2], win_r[1]} : win_r;
    c1      = pop ? 2'd2 : c0;
    c2      = c1 + 2'd1;
    for (int k = 0; k < 3; k++) begin
      win_nxt[k] = (c1 == 2'(k)) ? payload_byte : shifted[k];
    end

    job.open        = !inside_r;
    job.pop_en      = pop;
    job.pop_esc     = pop && (({w3, payload_byte} == delim) || (w3 == esc));
    job.pop_byte    = win_r[0];
    job.flush_n     = frame_last ? c2 : 2'd0;
    job.flush_bytes = win_nxt;
    job.flush_esc   = frame_last && (c2 == 2'd3) &&
                      ({win_nxt[0], win_nxt[1], win_nxt[2]} == esc);
    job.close       = frame_last;

    push       = acc && (job.open || pop || frame_last);
    count_nxt  = frame_last ? 2'd0 : c2;
    inside_nxt = !frame_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      inside_r <= 1'b0;
    end else if (acc) begin
      count_r  <= count_nxt;
      inside_r <= inside_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      win_r <= win_nxt;
    end
  end

endmodule

[design/tsf_queue.sv]
module tsf_queue #(
  parameter int DEPTH = tsf_pkg::QDEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tsf_pkg::job_t wr_job,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output tsf_pkg::job_t rd_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tsf_pkg::job_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_job    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_job;
    end
  end

endmodule

[design/tsf_back.sv]
module tsf_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  tsf_pkg::job_t job,
  input  logic [31:0]   delim,
  input  logic [23:0]   esc,
  output logic          job_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_stuffed_byte,
  output logic          out_run_last,
  output logic          out_frame_done
);

  logic            busy_r;
  tsf_pkg::phase_t phase_r;
  logic [1:0]      idx_r;
  logic            ovalid_r;
  logic [7:0]      obyte_r;
  logic            orun_r, odone_r;

  logic [5:0]      en, first, cur_vec, above, nxt;
  tsf_pkg::phase_t cur_ph;
  logic [1:0]      cur_idx;
  logic            phase_end, job_end, adv;
  logic [7:0]      cur_byte;
  logic [31:0]     dsh;
  logic [23:0]     esh;

  always_comb begin
    en      = {job.close, job.flush_n != 2'd0, job.flush_esc,
               job.pop_en, job.pop_esc, job.open};
    first   = en & (~en + 6'd1);
    cur_vec = busy_r ? phase_r : first;
    cur_ph  = tsf_pkg::phase_t'(cur_vec);
    cur_idx = busy_r ? idx_r : 2'd0;
    above   = en & ~({cur_vec[4:0], 1'b0} - 6'd1);
    nxt     = above & (~above + 6'd1);
    job_end = (nxt == 6'd0);
    dsh     = delim >> {~cur_idx, 3'b000};
    esh     = esc >> {2'd2 - cur_idx, 3'b000};

    unique case (cur_ph)
      tsf_pkg::PH_OPEN, tsf_pkg::PH_CLOSE: begin
        phase_end = (cur_idx == 2'd3);
        cur_byte  = dsh[7:0];
      end
      tsf_pkg::PH_PESC, tsf_pkg::PH_FESC: begin
        phase_end = (cur_idx == 2'd2);
        cur_byte  = esh[7:0];
      end
      tsf_pkg::PH_POP: begin
        phase_end = 1'b1;
        cur_byte  = job.pop_byte;
      end
      tsf_pkg::PH_FLUSH: begin
        phase_end = (cur_idx == job.flush_n - 2'd1);
        cur_byte  = job.flush_bytes[cur_idx];
      end
      default: begin
        phase_end = 1'b1;
        cur_byte  = 8'd0;
      end
    endcase

    adv     = job_valid && (!ovalid_r || !out_stall);
    job_pop = adv && phase_end && job_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      phase_r  <= tsf_pkg::PH_OPEN;
      idx_r    <= 2'd0;
      ovalid_r <= 1'b0;
    end else begin
      if (adv) begin
        ovalid_r <= 1'b1;
        if (phase_end) begin
          idx_r <= 2'd0;
          if (job_end) begin
            busy_r <= 1'b0;
          end else begin
            busy_r  <= 1'b1;
            phase_r <= tsf_pkg::phase_t'(nxt);
          end
        end else begin
          busy_r  <= 1'b1;
          phase_r <= cur_ph;
          idx_r   <= cur_idx + 2'd1;
        end
      end else if (!out_stall) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      obyte_r <= cur_byte;
      orun_r  <= phase_end && job_end;
      odone_r <= (cur_ph == tsf_pkg::PH_CLOSE) && (cur_idx == 2'd3);
    end
  end

  assign out_valid        = ovalid_r;
  assign out_stuffed_byte = obyte_r;
  assign out_run_last     = orun_r;
  assign out_frame_done   = odone_r;

endmodule

[design/token_stuffing_framer.sv]
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+-------------------------------------------
// in_       | input     | in_valid / in_stall  | in_payload_byte[7:0], in_frame_last
// out_      | output    | out_valid / out_stall| out_stuffed_byte[7:0], out_run_last,
//           |           |                      | out_frame_done
// config    | APB       | psel/penable/pready  | paddr[2:0], pwdata/prdata[31:0]
//
// Rates: the back end sends one stuffed byte per cycle while out_stall is low, so an
//   item's cost is the bytes it causes: none while the window fills, up to 14 for a
//   frame's closing item. The front end takes one item per cycle while the job queue
//   (QDEPTH entries) has room; the back end's byte rate sets the sustained figure.
// Reset (rst_n low, synchronous): empty the queue and output register, close any
//   frame, clear the window count and load the default flag/esc words.
// Stalls: out_stall holds the output register; the queue absorbs items until full,
//   then in_stall rises.
module token_stuffing_framer #(
  parameter int QDEPTH = tsf_pkg::QDEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_payload_byte,
  input  logic        in_frame_last,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_stuffed_byte,
  output logic        out_run_last,
  output logic        out_frame_done,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0]   delim_r;
  logic [23:0]   esc_r;
  logic          cfg_wr;
  logic          q_full, q_not_empty, q_push, q_pop, in_acc;
  tsf_pkg::job_t front_job, head_job;

  // Configuration registers: decode on paddr[2], ignore the low address bits.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == tsf_pkg::REG_ESC) ? {8'd0, esc_r} : delim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= tsf_pkg::DELIM_RESET;
      esc_r   <= tsf_pkg::ESC_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == tsf_pkg::REG_DELIM) begin
        delim_r <= pwdata;
      end else begin
        esc_r <= pwdata[23:0];
      end
    end
  end

  // Front end: accept an item whenever the queue has room, track the
  // lookahead window and turn the item into a job.
  assign in_stall = q_full;
  assign in_acc   = in_valid && !q_full;

  tsf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (in_acc),
    .payload_byte (in_payload_byte),
    .frame_last   (in_frame_last),
    .delim        (delim_r),
    .esc          (esc_r),
    .push         (q_push),
    .job          (front_job)
  );

  // Job queue: decouple item acceptance from byte emission.
  tsf_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_job    (front_job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .rd_job    (head_job)
  );

  // Back end: walk each job's phases and emit one byte per cycle unless out_stall holds it.
  tsf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_valid        (q_not_empty),
    .job              (head_job),
    .delim            (delim_r),
    .esc              (esc_r),
    .job_pop          (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_stuffed_byte (out_stuffed_byte),
    .out_run_last     (out_run_last),
    .out_frame_done   (out_frame_done)
  );

endmodule

[design/tsf_checker.sv]
module tsf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_stuffed_byte,
  input logic       out_run_last,
  input logic       out_frame_done,
  input logic       pready
);

  // a held output item keeps its byte
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_stuffed_byte))
    else $error("stalled output item changed");

  // the closing delimiter byte always ends its item's run
  a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_run_last)
    else $error("frame_done without run_last");

  // nothing is shown right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // the config port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready low");

endmodule

bind token_stuffing_framer tsf_checker u_tsf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_stuffed_byte (out_stuffed_byte),
  .out_run_last     (out_run_last),
  .out_frame_done   (out_frame_done),
  .pready           (pready)
);

[dv/stuffed_stream_monitor.sv]
`timescale 1ns / 1ps

module stuffed_stream_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_payload_byte,
  input  logic        in_frame_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_stuffed_byte,
  input  logic        out_run_last,
  input  logic        out_frame_done,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count,
  output int          backlog
);

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       frame_done;
  } stuffed_t;

  stuffed_t    expected_bytes[$];
  stuffed_t    batch[$];
  logic [31:0] delim_word;
  logic [23:0] esc_word;
  logic [7:0]  window [3];
  int          held;
  bit          framing;
  int          mismatches = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic add_byte(input logic [7:0] b, input logic done);
    stuffed_t r;
    r.data       = b;
    r.run_last   = 1'b0;
    r.frame_done = done;
    batch.push_back(r);
  endtask

  task automatic add_escape();
    add_byte(esc_word[23:16], 1'b0);
    add_byte(esc_word[15:8], 1'b0);
    add_byte(esc_word[7:0], 1'b0);
  endtask

  task automatic add_delimiter(input logic closing);
    add_byte(delim_word[31:24], 1'b0);
    add_byte(delim_word[23:16], 1'b0);
    add_byte(delim_word[15:8], 1'b0);
    add_byte(delim_word[7:0], closing);
  endtask

  // Work out the stuffed bytes that one payload item causes.
  task automatic stuff_payload_byte(input logic [7:0] b, input logic last);
    logic [23:0] w3;
    stuffed_t    tail;
    int          i;
    batch.delete();
    if (!framing) begin
      add_delimiter(1'b0);
      framing = 1'b1;
      held    = 0;
    end
    if (held == 3) begin
      w3 = {window[0], window[1], window[2]};
      if ({w3, b} == delim_word || w3 == esc_word) add_escape();
      add_byte(window[0], 1'b0);
      window[0] = window[1];
      window[1] = window[2];
      held      = 2;
    end
    window[held] = b;
    held++;
    if (last) begin
      // near the end only an escape word can still fit
      for (i = 0; i < held; i++) begin
        if (held - i >= 3) begin
          w3 = {window[i], window[i+1], window[i+2]};
          if (w3 == esc_word) add_escape();
        end
        add_byte(window[i], 1'b0);
      end
      add_delimiter(1'b1);
      held    = 0;
      framing = 1'b0;
    end
    if (batch.size() > 0) begin
      tail = batch.pop_back();
      tail.run_last = 1'b1;
      batch.push_back(tail);
    end
    foreach (batch[k]) expected_bytes.push_back(batch[k]);
  endtask

  always @(posedge clk) begin
    stuffed_t want;
    if (!rst_n) begin
      delim_word = tsf_pkg::DELIM_RESET;
      esc_word   = tsf_pkg::ESC_RESET;
      held       = 0;
      framing    = 1'b0;
      expected_bytes.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == tsf_pkg::REG_DELIM) delim_word = pwdata;
          else esc_word = pwdata[23:0];
        end else if (paddr[2] == tsf_pkg::REG_DELIM) begin
          if (prdata != delim_word) report_mismatch("delimiter read", prdata, delim_word);
        end else if (prdata != {8'h00, esc_word}) begin
          report_mismatch("escape read", prdata, {8'h00, esc_word});
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("result with nothing pending", 32'(out_stuffed_byte), 32'h0);
        end else begin
          want = expected_bytes.pop_front();
          if (out_stuffed_byte != want.data)
            report_mismatch("stuffed_byte", 32'(out_stuffed_byte), 32'(want.data));
          if (out_run_last != want.run_last)
            report_mismatch("run_last", 32'(out_run_last), 32'(want.run_last));
          if (out_frame_done != want.frame_done)
            report_mismatch("frame_done", 32'(out_frame_done), 32'(want.frame_done));
        end
      end
      if (in_valid && !in_stall) stuff_payload_byte(in_payload_byte, in_frame_last);
    end
    backlog    <= expected_bytes.size();
    fail_count <= mismatches;
  end

endmodule

[dv/token_stuffing_framer_tb.sv]
`timescale 1ns / 1ps

module token_stuffing_framer_tb;

  localparam int LONG_HOLD     = 400;  // receiver hold-off, long enough to back up the queue
  localparam int SETTLE_CYCLES = 40;   // covers the deepest job queue plus a closing item
  localparam int PHASE_ITEMS   = 50;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_payload_byte;
  logic        in_frame_last;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_stuffed_byte;
  logic        out_run_last;
  logic        out_frame_done;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          backlog;

  // quiet: no idling on either side; hold_req: ask the receiver for one long hold-off
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  // current register words, used only to steer frame content toward matches
  logic [31:0] cur_delim = tsf_pkg::DELIM_RESET;
  logic [23:0] cur_esc = tsf_pkg::ESC_RESET;
  logic [7:0]  frame_bytes[$];

  always #4 clk = ~clk;

  token_stuffing_framer uut (.*);

  stuffed_stream_monitor monitor (.*);

  // Hard stop in case the block hangs; several times the slowest legal run.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Receiver: random stall bursts, free-running stretches, and one long hold-off on request.
  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // One APB transfer: setup cycle, access cycle, then drop the select.
  task automatic cfg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Write both registers, then read them back for the monitor to check.
  task automatic apply_setting(input logic [31:0] delim, input logic [31:0] esc_raw);
    cfg_access(1'b1, {tsf_pkg::REG_DELIM, 2'b00}, delim);
    cfg_access(1'b1, {tsf_pkg::REG_ESC, 2'b00}, esc_raw);
    cfg_access(1'b0, {tsf_pkg::REG_DELIM, 2'b00}, 32'h0);
    cfg_access(1'b0, {tsf_pkg::REG_ESC, 2'b00}, 32'h0);
    cur_delim = delim;
    cur_esc   = esc_raw[23:0];
  endtask

  // Offer one item (after an idle gap now and then, unless quiet) and hold it until taken. Valid
  // stays high afterward so that back-to-back items go out without a bubble; the caller drops it when done.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_payload_byte <= b;
    in_frame_last   <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_queued();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Mostly short frames, a few long ones.
  function automatic int frame_length();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 8);
    if (r < 19) return $urandom_range(9, 20);
    return $urandom_range(21, 40);
  endfunction

  // Build a frame rich in whole and partial delimiter and escape words; the
  // truncation at the end leaves partial words right at the frame boundary.
  task automatic fill_frame(input int len);
    int pick;
    frame_bytes.delete();
    while (frame_bytes.size() < len) begin
      case ($urandom_range(0, 7))
        0, 1: begin
          for (int k = 3; k >= 0; k--) frame_bytes.push_back(cur_delim[8*k +: 8]);
        end
        2: begin
          for (int k = 2; k >= 0; k--) frame_bytes.push_back(cur_esc[8*k +: 8]);
        end
        3, 4: begin
          pick = $urandom_range(0, 6);
          if (pick < 4) frame_bytes.push_back(cur_delim[8*(3-pick) +: 8]);
          else frame_bytes.push_back(cur_esc[8*(6-pick) +: 8]);
        end
        default: frame_bytes.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    while (frame_bytes.size() > len) void'(frame_bytes.pop_back());
  endtask

  // Drop valid, wait for every expected byte, then let the block go quiet.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Send whole frames until at least the given number of items went out.
  task automatic run_phase(input int items);
    int sent;
    int len;
    sent = 0;
    while (sent < items) begin
      len = frame_length();
      fill_frame(len);
      send_queued();
      sent += len;
    end
    drain();
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_payload_byte <= 8'h00;
    in_frame_last   <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= 3'b000;
    pwdata          <= 32'h0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames on the reset words ("flag" / "esc").
    // single-byte frames at both byte extremes
    frame_bytes = '{8'h00};
    send_queued();
    frame_bytes = '{8'hFF};
    send_queued();
    // whole frame is the delimiter: escape on its first byte
    frame_bytes = '{8'h66, 8'h6C, 8'h61, 8'h67};
    send_queued();
    // whole frame is the escape word: caught while flushing
    frame_bytes = '{8'h65, 8'h73, 8'h63};
    send_queued();
    // escape word followed by one more byte: caught in the window
    frame_bytes = '{8'h65, 8'h73, 8'h63, 8'h21};
    send_queued();
    // delimiter then escape word back to back
    frame_bytes = '{8'h66, 8'h6C, 8'h61, 8'h67, 8'h65, 8'h73, 8'h63};
    send_queued();
    // partial delimiter at the frame end must pass untouched
    frame_bytes = '{8'h66, 8'h6C, 8'h61};
    send_queued();
    drain();

    // read back the reset words before touching them
    cfg_access(1'b0, {tsf_pkg::REG_DELIM, 2'b00}, 32'h0);
    cfg_access(1'b0, {tsf_pkg::REG_ESC, 2'b00}, 32'h0);
    run_phase(PHASE_ITEMS);

    // all-ones delimiter; escape written with junk above its 24 bits
    apply_setting(32'hFFFF_FFFF, 32'hFF00_0000);
    run_phase(PHASE_ITEMS);

    // all-zero delimiter, all-ones escape; hold off the receiver to fill the queue
    apply_setting(32'h0000_0000, 32'h00FF_FFFF);
    hold_req = 1'b1;
    run_phase(PHASE_ITEMS + 10);

    // self-overlapping words: one repeated byte in both
    apply_setting(32'hAAAA_AAAA, 32'h55AA_AAAA);
    run_phase(PHASE_ITEMS);

    apply_setting($urandom, $urandom);
    run_phase(PHASE_ITEMS);

    // last part runs at full rate on both sides
    quiet = 1'b1;
    apply_setting(tsf_pkg::DELIM_RESET, {8'h00, tsf_pkg::ESC_RESET});
    run_phase(40);

    if (fail_count == 0 && backlog == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
design/tsf_pkg.sv
design/tsf_front.sv
design/tsf_queue.sv
design/tsf_back.sv
design/token_stuffing_framer.sv
design/tsf_checker.sv
dv/stuffed_stream_monitor.sv
dv/token_stuffing_framer_tb.sv
